FILE: design/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

    // Frame and field widths.
    localparam int FRAME_W = 16;
    localparam int COUNT_W = 17;
    localparam int LIMIT_W = 17;

    // The bitmap is kept as 16-bit words, one bit per frame.
    localparam int WORD_W     = 16;
    localparam int BIT_W      = 4;
    localparam int WORD_DEPTH = 4096;
    localparam int WADDR_W    = 12;

    localparam logic [LIMIT_W-1:0] MAX_FRAMES  = 17'd65536;
    localparam logic [LIMIT_W-1:0] RESET_LIMIT = 17'd65536;
    localparam logic [WORD_W-1:0]  WORD_ONES   = 16'hFFFF;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    // Control handed to the word unit for the word now on the read port.
    typedef struct packed {
        logic [WADDR_W-1:0] cur;
        logic [FRAME_W-1:0] lo;
        logic [FRAME_W-1:0] last;
        logic [COUNT_W-1:0] need;
        logic [COUNT_W-1:0] cnt;
    } word_ctl_t;

    // Status returned by the word unit.
    typedef struct packed {
        logic [WORD_W-1:0]  mask;
        logic               hit;
        logic [BIT_W-1:0]   hit_bit;
        logic [COUNT_W-1:0] need_next;
    } word_res_t;

endpackage

FILE: design/bfa_req_if.sv
`timescale 1ns / 1ps

interface bfa_req_if
    import bfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [FRAME_W-1:0] start_frame;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output op, output start_frame, output count, input ready);
    modport sink (input valid, input op, input start_frame, input count, output ready);
endinterface

FILE: design/bfa_rsp_if.sv
`timescale 1ns / 1ps

interface bfa_rsp_if
    import bfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [FRAME_W-1:0] frame;

    modport source (output valid, output ok, output frame, input ready);
    modport sink (input valid, input ok, input frame, output ready);
endinterface

FILE: design/bfa_cfg_if.sv
`timescale 1ns / 1ps

interface bfa_cfg_if
    import bfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink (input valid, input frames_in_use, output ready);
endinterface

FILE: design/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bfa_word_unit.sv
`timescale 1ns / 1ps

// Works on one bitmap word: builds the frame range mask and, for the scan,
// finds the first free frame that completes a run of the requested length.
module bfa_word_unit
    import bfa_pkg::*;
(
    input  logic [WORD_W-1:0] data,
    input  word_ctl_t         ctl,
    output word_res_t         res
);

    always_comb
    begin
        logic [WORD_W-1:0] lo_mask;
        logic [WORD_W-1:0] hi_mask;
        logic              has;
        logic [BIT_W-1:0]  lu;
        logic [BIT_W:0]    gap_len;
        logic              cond;
        logic              found;
        logic [BIT_W-1:0]  fj;

        lo_mask = (ctl.cur == ctl.lo[FRAME_W-1:BIT_W]) ?
                  (WORD_ONES << ctl.lo[BIT_W-1:0]) : WORD_ONES;
        hi_mask = (ctl.cur == ctl.last[FRAME_W-1:BIT_W]) ?
                  (WORD_ONES >> (4'd15 - ctl.last[BIT_W-1:0])) : WORD_ONES;
        res.mask = lo_mask & hi_mask;

        has     = 1'b0;
        lu      = '0;
        gap_len = '0;
        cond    = 1'b0;
        found   = 1'b0;
        fj      = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (!found && res.mask[j] && !data[j])
            begin
                // With no used frame yet in this word the run carries over
                // from earlier words, tracked as the frames still needed.
                if (!has)
                begin
                    cond = ({12'd0, 5'(j + 1)} >= ctl.need);
                end
                else
                begin
                    gap_len = 5'(j) - {1'b0, lu};
                    cond    = ({12'd0, gap_len} >= ctl.cnt);
                end
                if (cond)
                begin
                    found = 1'b1;
                    fj    = 4'(j);
                end
            end
            if (data[j])
            begin
                has = 1'b1;
                lu  = 4'(j);
            end
        end

        res.hit     = found;
        res.hit_bit = fj;
        res.need_next = !has ? (ctl.need - 17'd16) :
                        (ctl.cnt - {13'd0, 4'd15 - lu});
    end

endmodule

FILE: design/bitmap_frame_allocator.sv
`timescale 1ns / 1ps

// First-fit page frame allocator over a bitmap of 65536 frames, one bit per
// frame, where a set bit marks a frame in use.
// Requests arrive on req (op, start_frame, count) and each one gives exactly
// one beat on rsp (ok, frame). The limit register is written through cfg,
// which is always ready; write it only while no request is in flight.
// The bitmap lives in a 4096 x 16 RAM, and a single word unit handles one
// word per cycle under a small sequencer; req is not ready while a request
// is at work.
// A rejected request goes straight to the push step. Free primes the
// first word of the range, then clears the range word by word. Reserve
// runs a check pass, then a mark pass. Allocate scans from frame 0 up to
// the word holding the run's end, one word a cycle, then marks the run.
// After reset a clearing pass over all 4096 words fills the bitmap with
// ones (every frame used); req stays low meanwhile, cfg writes are taken.
// The result sits in an output register: a stalled receiver does not stop
// the next request from being accepted, but a finished result waits in the
// sequencer until the output register is free.
module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bfa_cfg_if.sink      cfg,
    bfa_req_if.sink      req,
    bfa_rsp_if.source    rsp
);

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PRIME = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_MARK  = 8'b0010_0000,
        S_CLEAR = 8'b0100_0000,
        S_PUSH  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    state_t             tgt_reg, tgt_next;
    logic [WADDR_W-1:0] cur_reg, cur_next;
    logic [FRAME_W-1:0] lo_reg, lo_next;
    logic [FRAME_W-1:0] last_reg, last_next;
    logic [COUNT_W-1:0] need_reg, need_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               res_ok_reg, res_ok_next;
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [FRAME_W-1:0] out_frame_reg, out_frame_next;
    logic [LIMIT_W-1:0] frames_reg;

    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W:0]   sum;
    logic [LIMIT_W-1:0] hi;
    logic [FRAME_W-1:0] s;
    logic               last_word;

    logic               ram_we;
    logic [WADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;

    word_ctl_t          ctl;
    word_res_t          wres;

    // Configuration is taken at any time.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= RESET_LIMIT;
        end
        else if (cfg.valid)
        begin
            frames_reg <= cfg.frames_in_use;
        end
    end

    // The effective limit saturates at the bitmap size.
    assign lim = (frames_reg > MAX_FRAMES) ? MAX_FRAMES : frames_reg;

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The prime step fetches the first word of a pass; inside a pass the
    // next word is fetched while the current one is worked on and written.
    assign ram_raddr = (state_reg == S_PRIME) ? lo_reg[FRAME_W-1:BIT_W] :
                       (cur_reg + 12'd1);

    assign ctl.cur  = cur_reg;
    assign ctl.lo   = lo_reg;
    assign ctl.last = last_reg;
    assign ctl.need = need_reg;
    assign ctl.cnt  = cnt_reg;

    bfa_word_unit u_word (
        .data (ram_rdata),
        .ctl  (ctl),
        .res  (wres)
    );

    assign last_word = (cur_reg == last_reg[FRAME_W-1:BIT_W]);
    assign sum = 18'(req.start_frame) + 18'(req.count);
    assign hi  = (sum > {1'b0, lim}) ? lim : sum[LIMIT_W-1:0];
    // Start of the run whose last frame was just found by the scan.
    assign s = 16'({1'b0, cur_reg, wres.hit_bit} + 17'd1 - cnt_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.ok    = out_ok_reg;
    assign rsp.frame = out_frame_reg;

    always_comb
    begin
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        last_next      = last_reg;
        need_next      = need_reg;
        cnt_next       = cnt_reg;
        res_ok_next    = res_ok_reg;
        res_frame_next = res_frame_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_frame_next = out_frame_reg;
        ram_we         = 1'b0;
        ram_wdata      = WORD_ONES;

        case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                if (cur_reg == 12'hFFF)
                begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + 12'd1;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_ok_next    = 1'b0;
                    res_frame_next = '0;
                    need_next      = req.count;
                    cnt_next       = req.count;
                    state_next     = S_PUSH;
                    case (req.op)
                        OP_ALLOC:
                        begin
                            if (req.count != '0 && lim != '0)
                            begin
                                lo_next    = '0;
                                last_next  = 16'(lim - 17'd1);
                                tgt_next   = S_SCAN;
                                state_next = S_PRIME;
                            end
                        end
                        OP_FREE:
                        begin
                            if (req.count != '0 && {1'b0, req.start_frame} < lim)
                            begin
                                lo_next    = req.start_frame;
                                last_next  = 16'(hi - 17'd1);
                                tgt_next   = S_CLEAR;
                                state_next = S_PRIME;
                            end
                        end
                        OP_RESERVE:
                        begin
                            if (sum <= {1'b0, lim})
                            begin
                                if (req.count == '0)
                                begin
                                    res_ok_next = 1'b1;
                                end
                                else
                                begin
                                    lo_next    = req.start_frame;
                                    last_next  = 16'(sum - 18'd1);
                                    tgt_next   = S_CHECK;
                                    state_next = S_PRIME;
                                end
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            S_PRIME:
            begin
                cur_next   = lo_reg[FRAME_W-1:BIT_W];
                state_next = tgt_reg;
            end

            S_SCAN:
            begin
                if (wres.hit)
                begin
                    lo_next        = s;
                    last_next      = {cur_reg, wres.hit_bit};
                    res_ok_next    = 1'b1;
                    res_frame_next = s;
                    tgt_next       = S_MARK;
                    state_next     = S_PRIME;
                end
                else if (last_word)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cur_next  = cur_reg + 12'd1;
                    need_next = wres.need_next;
                end
            end

            S_CHECK:
            begin
                if ((ram_rdata & wres.mask) != '0)
                begin
                    state_next = S_PUSH;
                end
                else if (last_word)
                begin
                    tgt_next   = S_MARK;
                    state_next = S_PRIME;
                end
                else
                begin
                    cur_next = cur_reg + 12'd1;
                end
            end

            S_MARK, S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (state_reg == S_MARK) ? (ram_rdata | wres.mask) :
                            (ram_rdata & ~wres.mask);
                if (last_word)
                begin
                    res_ok_next = 1'b1;
                    state_next  = S_PUSH;
                end
                else
                begin
                    cur_next = cur_reg + 12'd1;
                end
            end

            S_PUSH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_frame_next = res_frame_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
                cur_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            tgt_reg       <= S_SCAN;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tgt_reg       <= tgt_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        last_reg      <= last_next;
        need_reg      <= need_next;
        cnt_reg       <= cnt_next;
        res_ok_reg    <= res_ok_next;
        res_frame_reg <= res_frame_next;
        out_ok_reg    <= out_ok_next;
        out_frame_reg <= out_frame_next;
    end

endmodule

FILE: test/bitmap_frame_allocator_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the first-fit bitmap frame allocator.
//
// The bench keeps a shadow copy of the frame bitmap and of the limit
// register. Each request beat that the block accepts is applied to that
// shadow copy right away. The reply that it should give is queued, and a
// separate process compares every reply beat on rsp against the oldest
// queued reply, one field at a time.
module bitmap_frame_allocator_tb;
    import bfa_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_MAX      = 7;
    localparam int SETTLE_CYCLES = 64;
    localparam int N_FRAMES      = 65536;

    // The block rejects op 3. It is given a name here so that the stimulus
    // can use it like the other operation codes.
    localparam logic [1:0] OP_UNDEF = 2'd3;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
    } alloc_reply_t;

    logic clk;
    logic rst_n;

    bfa_cfg_if cfg_bus ();
    bfa_req_if req_bus ();
    bfa_rsp_if rsp_bus ();

    bitmap_frame_allocator dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow state. A set bit in frame_busy means that the frame is in use.
    bit                 frame_busy [N_FRAMES];
    logic [LIMIT_W-1:0] managed_frames;

    // Replies still owed by the block, oldest first.
    alloc_reply_t outstanding_replies [$];

    int mismatch_count;

    // When set, the request side or the reply side does not idle at all.
    // This gives stretches of back-to-back beats.
    bit src_quiet;
    bit sink_quiet;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The limit register can hold values above MAX_FRAMES. The block then
    // clamps its working limit to the size of the bitmap.
    function automatic int unsigned active_limit();
        if (managed_frames > MAX_FRAMES)
            return 32'(MAX_FRAMES);
        return 32'(managed_frames);
    endfunction

    // This marks a span as used, but only if the whole span lies below the
    // limit and every frame in it is free. Otherwise nothing changes.
    function automatic bit claim_span(input int unsigned base, input int unsigned cnt);
        int unsigned i;
        if (base + cnt > active_limit())
            return 1'b0;
        for (i = 0; i < cnt; i++)
        begin
            if (frame_busy[base + i])
                return 1'b0;
        end
        for (i = 0; i < cnt; i++)
            frame_busy[base + i] = 1'b1;
        return 1'b1;
    endfunction

    // This applies one request to the shadow bitmap and returns the reply
    // that the block owes for it.
    function automatic alloc_reply_t apply_frame_request
    (
        input logic [1:0]         op,
        input logic [FRAME_W-1:0] first,
        input logic [COUNT_W-1:0] n
    );
        alloc_reply_t reply;
        int unsigned  lim;
        int unsigned  cnt;
        int unsigned  base;
        int unsigned  run;
        int unsigned  f;
        int unsigned  i;
        reply = '0;
        lim   = active_limit();
        cnt   = 32'(n);
        base  = 32'(first);
        case (op)
            OP_ALLOC:
            begin
                // First fit: the lowest run of cnt free frames below the
                // limit wins. A count of zero always fails.
                if (cnt != 0)
                begin
                    run = 0;
                    for (f = 0; f < lim; f++)
                    begin
                        if (frame_busy[f])
                        begin
                            run = 0;
                        end
                        else
                        begin
                            run++;
                            if (run == cnt)
                            begin
                                void'(claim_span(f + 1 - cnt, cnt));
                                reply.ok    = 1'b1;
                                reply.frame = FRAME_W'(f + 1 - cnt);
                                break;
                            end
                        end
                    end
                end
            end
            OP_FREE:
            begin
                // A free that runs past the limit is cut off there and
                // still succeeds.
                if (cnt != 0 && base < lim)
                begin
                    for (i = 0; i < cnt; i++)
                    begin
                        if (base + i >= lim)
                            break;
                        frame_busy[base + i] = 1'b0;
                    end
                    reply.ok = 1'b1;
                end
            end
            OP_RESERVE:
            begin
                reply.ok = claim_span(base, cnt);
            end
            default:
            begin
                reply = '0;
            end
        endcase
        return reply;
    endfunction

    // This sends one request beat. It is called right after a rising edge.
    // The valid signal is left high after the beat, so that a request with
    // no gap follows with no dip in valid. The idle gap of the next call,
    // or a drain, lowers it.
    task automatic send_request
    (
        input logic [1:0]         op,
        input logic [FRAME_W-1:0] first,
        input logic [COUNT_W-1:0] n
    );
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.op          <= op;
        req_bus.start_frame <= first;
        req_bus.count       <= n;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        outstanding_replies.push_back(apply_frame_request(op, first, n));
    endtask

    // This lowers valid and waits until every owed reply has come back. Every
    // request gives exactly one reply, so the block is idle after that.
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        while (outstanding_replies.size() != 0)
            @(posedge clk);
    endtask

    // This writes the limit register while the block is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        cfg_bus.valid         <= 1'b1;
        cfg_bus.frames_in_use <= value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid  <= 1'b0;
        managed_frames = value;
    endtask

    // This draws one request with random content. Most starts and counts lie
    // within the current limit, so that allocations, frees and reserves
    // interact with each other. Some have full-width values, and some
    // requests are malformed.
    task automatic send_random_request(input int unsigned lim);
        int unsigned pick;
        int unsigned cap;
        int unsigned first;
        int unsigned n;
        logic [1:0]  op;
        cap  = (lim == 0) ? 1 : lim;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            first = $urandom_range(0, 65535);
        else
            first = $urandom_range(0, cap - 1);
        case ($urandom_range(0, 9))
            0: n = 0;
            1: n = $urandom_range(0, 131071);
            2: n = $urandom_range(0, cap + 8);
            default: n = $urandom_range(1, (cap < 32) ? cap : 32);
        endcase
        if (pick < 38)
            op = OP_ALLOC;
        else if (pick < 68)
            op = OP_FREE;
        else if (pick < 93)
            op = OP_RESERVE;
        else
            op = OP_UNDEF;
        // Now and then the whole managed range is released. This keeps
        // the bitmap from filling up for good.
        if (pick < 3)
        begin
            op    = OP_FREE;
            first = 0;
            n     = cap;
        end
        send_request(op, FRAME_W'(first), COUNT_W'(n));
    endtask

    // Straight out of reset, every frame is in use.
    task automatic test_reset_state();
        send_request(OP_ALLOC, 16'd0, 17'd1);
        send_request(OP_RESERVE, 16'd0, 17'd0);
        send_request(OP_RESERVE, 16'd100, 17'd1);
        send_request(OP_FREE, 16'd5, 17'd0);
        send_request(OP_UNDEF, 16'hFFFF, 17'h1FFFF);
    endtask

    // Corner cases under a small limit: a free that runs past the limit,
    // a full fit, no room, reserve conflicts, a reserve past the limit,
    // zero counts and a start at the limit.
    task automatic test_small_limit();
        write_limit(17'd64);
        send_request(OP_FREE, 16'd0, 17'h1FFFF);
        send_request(OP_ALLOC, 16'd0, 17'd64);
        send_request(OP_ALLOC, 16'd0, 17'd1);
        send_request(OP_FREE, 16'd64, 17'd1);
        send_request(OP_FREE, 16'd10, 17'd5);
        send_request(OP_RESERVE, 16'd10, 17'd6);
        send_request(OP_RESERVE, 16'd10, 17'd5);
        send_request(OP_FREE, 16'd0, 17'd64);
        send_request(OP_RESERVE, 16'd60, 17'd5);
        send_request(OP_RESERVE, 16'd64, 17'd0);
        send_request(OP_RESERVE, 16'd65, 17'd0);
        send_request(OP_ALLOC, 16'd0, 17'd0);
        send_request(OP_ALLOC, 16'd0, 17'd65);
    endtask

    // With a limit of zero, nothing can be freed or allocated.
    task automatic test_zero_limit();
        write_limit(17'd0);
        send_request(OP_FREE, 16'd0, 17'd1);
        send_request(OP_ALLOC, 16'd0, 17'd1);
        send_request(OP_RESERVE, 16'd0, 17'd0);
    endtask

    // A limit above the bitmap size is clamped to it. A full clear and a
    // full allocation cover the whole bitmap, and the top frame is reached.
    task automatic test_saturated_limit();
        write_limit(17'h1FFFF);
        send_request(OP_FREE, 16'd0, 17'd65536);
        send_request(OP_ALLOC, 16'd0, 17'd65536);
        send_request(OP_FREE, 16'd65535, 17'd1);
        send_request(OP_ALLOC, 16'd0, 17'd1);
    endtask

    // These are random phases. Each one sets a new limit and then sends a
    // batch of requests. Most limits are small, so that allocation scans
    // stay short. Two phases use large limits, one of them above the full bitmap,
    // with short batches.
    task automatic test_random_traffic();
        int                 phase;
        int                 items;
        int                 k;
        logic [LIMIT_W-1:0] lim;
        for (phase = 0; phase < 14; phase++)
        begin
            items = 45;
            case (phase)
                2, 8:
                begin
                    lim = LIMIT_W'($urandom_range(0, 7));
                end
                4:
                begin
                    lim   = LIMIT_W'($urandom_range(4096, 65535));
                    items = 10;
                end
                9:
                begin
                    lim   = 17'h10000 | LIMIT_W'($urandom_range(0, 65535));
                    items = 10;
                end
                default:
                begin
                    lim = LIMIT_W'($urandom_range(8, 2048));
                end
            endcase
            write_limit(lim);
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            for (k = 0; k < items; k++)
                send_random_request(active_limit());
        end
    endtask

    // This process takes every reply beat. For each reply it draws how long
    // to stall. With no stall, ready stays high. Otherwise ready is held low
    // until valid shows up and then through the rest of the drawn stall, so
    // that stalls land on finished replies.
    initial
    begin : reply_monitor
        int           stall;
        alloc_reply_t want;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_quiet ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall == 0)
            begin
                rsp_bus.ready <= 1'b1;
            end
            else
            begin
                rsp_bus.ready <= 1'b0;
                do
                    @(posedge clk);
                while (rsp_bus.valid !== 1'b1);
                repeat (stall - 1) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (rsp_bus.valid !== 1'b1);
            // A reply beat has just been taken at this edge.
            if (outstanding_replies.size() == 0)
            begin
                $display("%0t: reply beat with no request waiting, ok %0d frame %0d",
                         $time, rsp_bus.ok, rsp_bus.frame);
                mismatch_count++;
            end
            else
            begin
                want = outstanding_replies.pop_front();
                if (rsp_bus.ok !== want.ok)
                begin
                    $display("%0t: ok mismatch, expected %0d, actual %0d",
                             $time, want.ok, rsp_bus.ok);
                    mismatch_count++;
                end
                if (rsp_bus.frame !== want.frame)
                begin
                    $display("%0t: frame mismatch, expected %0d, actual %0d",
                             $time, want.frame, rsp_bus.frame);
                    mismatch_count++;
                end
            end
        end
    end

    // This is the main sequence. Reset is applied once. After it comes the
    // directed corner cases, then the random phases, then a drain and a
    // short settle, so that a stray extra reply would still be caught.
    initial
    begin : main_sequence
        rst_n                 <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.op            <= OP_ALLOC;
        req_bus.start_frame   <= '0;
        req_bus.count         <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.frames_in_use <= '0;
        mismatch_count = 0;
        src_quiet      = 1'b0;
        sink_quiet     = 1'b0;
        managed_frames = RESET_LIMIT;
        foreach (frame_busy[f])
            frame_busy[f] = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_small_limit();
        test_zero_limit();
        test_saturated_limit();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // This watchdog allows several times the slowest legal run. It assumes
    // that every request scans the whole bitmap and then marks it, with the
    // longest gaps and stalls on both sides.
    initial
    begin : watchdog
        #(80_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
